// File: rtl/assert_macros.svh
// Assertion macros used by the hts_emit module of the tag strip filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define HTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define HTS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/hts_pkg.sv
// Package with the character codes, run descriptor type and helpers of the tag strip filter.
package hts_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CUT   = 8'hFF;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_G = 8'h67;
  localparam logic [7:0] CH_LOW_H = 8'h68;
  localparam logic [7:0] CH_LOW_L = 8'h6C;
  localparam logic [7:0] CH_LOW_M = 8'h6D;
  localparam logic [7:0] CH_LOW_P = 8'h70;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam int CAND_BR = 0;
  localparam int CAND_P  = 1;
  localparam int CAND_HR = 2;
  localparam logic [2:0] CAND_ALL = 3'b111;

  localparam logic [2:0] ENT_IDLE   = 3'd0;
  localparam logic [2:0] ENT_START  = 3'd1;
  localparam logic [2:0] ENT_THIRD  = 3'd3;
  localparam logic [2:0] ENT_FOURTH = 3'd4;

  localparam logic [2:0] TAG_LEN_MAX = 3'd7;

  // One run of output bytes caused by one item.
  typedef struct packed {
    logic            emit;
    logic            rule;
    logic [2:0]      last_idx;
    logic [4:0][7:0] bytes;
  } hts_run_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic hts_run_t single_run(input logic [7:0] b);
    hts_run_t r;
    r = '0;
    r.emit = 1'b1;
    r.bytes[0] = b;
    return r;
  endfunction

  // The ampersand and up to count collected bytes, cut before a NUL or 0xFF byte.
  function automatic hts_run_t raw_run(input logic [3:0][7:0] ent, input logic [2:0] count);
    hts_run_t r;
    logic     stop;
    r = '0;
    stop = 1'b0;
    r.emit = 1'b1;
    r.bytes[0] = CH_AMP;
    for (int i = 0; i < 4; i++) begin
      r.bytes[i+1] = ent[i];
      if (!stop && (3'(i) < count) && ent[i] != CH_NUL && ent[i] != CH_CUT) begin
        r.last_idx = 3'(i + 1);
      end else begin
        stop = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/hts_in_if.sv
// Input channel interface carrying one byte item and its end marker.
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// File: rtl/hts_out_if.sv
// Result channel interface carrying one filtered byte item and its run end flag.
interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/hts_parse.sv
// Parser holding tag and entity state and building the output run of each item.
module hts_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  input  logic              convert,
  output hts_pkg::hts_run_t run
);
  import hts_pkg::*;

  logic            inside_r, inside_nxt;
  logic [2:0]      len_r, len_nxt;
  logic [2:0]      cand_r, cand_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [3:0][7:0] ent_r, ent_nxt;
  logic [3:0][7:0] ent_w;
  logic [7:0]      lc;

  always_comb begin
    inside_nxt = inside_r;
    len_nxt    = len_r;
    cand_nxt   = cand_r;
    phase_nxt  = phase_r;
    ent_nxt    = ent_r;
    run        = '0;
    lc         = to_lower(in_byte);
    ent_w      = ent_r;
    ent_w[phase_r[1:0] - 2'd1] = in_byte;
    if (accept) begin
      if (end_of_input) begin
        if (phase_r != ENT_IDLE) begin
          run = raw_run(ent_r, phase_r - 3'd1);
        end
        inside_nxt = 1'b0;
        len_nxt    = '0;
        cand_nxt   = CAND_ALL;
        phase_nxt  = ENT_IDLE;
      end else if (phase_r != ENT_IDLE) begin
        ent_nxt = ent_w;
        if (phase_r == ENT_THIRD) begin
          if (ent_w[0] == CH_LOW_G && ent_w[1] == CH_LOW_T && ent_w[2] == CH_SEMI) begin
            run = single_run(CH_GT);
            phase_nxt = ENT_IDLE;
          end else if (ent_w[0] == CH_LOW_L && ent_w[1] == CH_LOW_T && ent_w[2] == CH_SEMI) begin
            run = single_run(CH_LT);
            phase_nxt = ENT_IDLE;
          end else if (!(ent_w[0] == CH_LOW_A && ent_w[1] == CH_LOW_M
                         && ent_w[2] == CH_LOW_P)) begin
            run = raw_run(ent_w, 3'd3);
            phase_nxt = ENT_IDLE;
          end else begin
            phase_nxt = ENT_FOURTH;
          end
        end else if (phase_r == ENT_FOURTH) begin
          if (ent_w[3] == CH_SEMI) begin
            run = single_run(CH_AMP);
          end else begin
            run = raw_run(ent_w, 3'd4);
          end
          phase_nxt = ENT_IDLE;
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end else if (in_byte == CH_LT) begin
        inside_nxt = 1'b1;
        len_nxt    = '0;
        cand_nxt   = CAND_ALL;
      end else if (in_byte == CH_GT) begin
        if (inside_r && convert) begin
          if ((cand_r[CAND_BR] && len_r == 3'd2) || (cand_r[CAND_P] && len_r == 3'd1)) begin
            run = single_run(CH_NL);
          end else if (cand_r[CAND_HR] && len_r == 3'd2) begin
            run = '0;
            run.emit = 1'b1;
            run.rule = 1'b1;
          end
        end
        inside_nxt = 1'b0;
        len_nxt    = '0;
        cand_nxt   = CAND_ALL;
      end else if (inside_r) begin
        if (len_r == 3'd0) begin
          if (lc != CH_LOW_B) cand_nxt[CAND_BR] = 1'b0;
          if (lc != CH_LOW_P) cand_nxt[CAND_P] = 1'b0;
          if (lc != CH_LOW_H) cand_nxt[CAND_HR] = 1'b0;
        end else if (len_r == 3'd1) begin
          cand_nxt[CAND_P] = 1'b0;
          if (lc != CH_LOW_R) begin
            cand_nxt[CAND_BR] = 1'b0;
            cand_nxt[CAND_HR] = 1'b0;
          end
        end else begin
          cand_nxt = '0;
        end
        if (len_r != TAG_LEN_MAX) begin
          len_nxt = len_r + 3'd1;
        end
      end else if (in_byte == CH_AMP) begin
        phase_nxt = ENT_START;
      end else begin
        run = single_run(in_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      len_r    <= '0;
      cand_r   <= CAND_ALL;
      phase_r  <= ENT_IDLE;
    end else begin
      inside_r <= inside_nxt;
      len_r    <= len_nxt;
      cand_r   <= cand_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: rtl/hts_emit.sv
// Result register that holds one output run and sends its bytes one per cycle while take is high.
`include "assert_macros.svh"

module hts_emit #(
  parameter int HR_RULE_LENGTH = 44
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hts_pkg::hts_run_t run,
  input  logic              take,
  output logic              busy,
  output logic              at_last,
  output logic [7:0]        out_byte
);
  import hts_pkg::*;

  localparam int POS_W = ($clog2(HR_RULE_LENGTH + 2) > 3) ? $clog2(HR_RULE_LENGTH + 2) : 3;
  localparam logic [POS_W-1:0] RULE_LAST = POS_W'(HR_RULE_LENGTH + 1);

  logic                 busy_r, busy_nxt;
  logic                 rule_r, rule_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     last_r, last_nxt;
  logic [4:0][7:0]      bytes_r, bytes_nxt;
  logic [7:0]           lit_byte;

  assign busy    = busy_r;
  assign at_last = (pos_r == last_r);

  always_comb begin
    case (pos_r[2:0])
      3'd0:    lit_byte = bytes_r[0];
      3'd1:    lit_byte = bytes_r[1];
      3'd2:    lit_byte = bytes_r[2];
      3'd3:    lit_byte = bytes_r[3];
      3'd4:    lit_byte = bytes_r[4];
      default: lit_byte = CH_NUL;
    endcase
    if (rule_r) begin
      out_byte = (pos_r == '0 || pos_r == last_r) ? CH_NL : CH_DASH;
    end else begin
      out_byte = lit_byte;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    rule_nxt  = rule_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    bytes_nxt = bytes_r;
    if (take && !at_last) begin
      pos_nxt = pos_r + POS_W'(1);
    end else if (load) begin
      busy_nxt  = run.emit;
      rule_nxt  = run.rule;
      pos_nxt   = '0;
      last_nxt  = run.rule ? RULE_LAST : POS_W'(run.last_idx);
      bytes_nxt = run.bytes;
    end else if (take) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rule_r <= 1'b0;
      pos_r  <= '0;
      last_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      rule_r <= rule_nxt;
      pos_r  <= pos_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  `HTS_ASSERT(a_rule_dash, clk, rst_n,
              !(busy_r && rule_r && pos_r != '0 && pos_r != last_r) || out_byte == CH_DASH,
              "rule body byte is not a dash")
  `HTS_ASSERT(a_lit_len, clk, rst_n, !(busy_r && !rule_r) || last_r <= POS_W'(4),
              "literal run longer than five bytes")
  `HTS_ASSERT_NEXT(a_hold, clk, rst_n, busy_r && !take,
                   busy_r && $stable(pos_r) && $stable(last_r), "waiting run changed")

endmodule

// File: rtl/html_tag_strip_filter.sv
// Top level of the HTML tag strip filter with entity decoding.
// The block accepts one byte item per cycle while the result register is free or its last
// byte is being taken. An item that yields output bytes holds the result register until its
// last byte is taken, and the next item is accepted in that cycle, so runs follow without gaps.
// A converted hr tag yields HR_RULE_LENGTH + 2 bytes, an unresolved entity up to five.
// There is no clearing pass after reset; items are accepted from the first cycle out of reset.
module html_tag_strip_filter #(
  parameter int HR_RULE_LENGTH = 44
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_data,
  hts_in_if.sink          in_ch,
  hts_out_if.source       out_ch
);
  import hts_pkg::*;

  logic     convert_r;
  logic     accept;
  logic     take;
  logic     busy;
  logic     at_last;
  hts_run_t run;

  assign take         = busy && out_ch.ready;
  assign in_ch.ready  = !busy || (out_ch.ready && at_last);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = busy;
  assign out_ch.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_r <= 1'b0;
    end else if (cfg_we) begin
      convert_r <= cfg_data;
    end
  end

  hts_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .convert      (convert_r),
    .run          (run)
  );

  hts_emit #(
    .HR_RULE_LENGTH (HR_RULE_LENGTH)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .run      (run),
    .take     (take),
    .busy     (busy),
    .at_last  (at_last),
    .out_byte (out_ch.out_byte)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for html_tag_strip_filter: directed and random byte streams checked byte by byte.
module tb;
  import hts_pkg::*;

  localparam int RULE_LEN = 44;
  localparam int HOLD_CYCLES = 300;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  hts_in_if  in_if();
  hts_out_if out_if();

  html_tag_strip_filter #(
    .HR_RULE_LENGTH(RULE_LEN)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  text_char_t expected_text[$];
  logic [7:0] run_q[$];

  logic       conv_mode;
  logic       in_tag;
  logic [2:0] tag_cnt;
  logic [2:0] live_tags;
  logic [2:0] amp_step;
  logic [7:0] amp_buf[4];

  bit idle_on;
  bit hold_req;
  int hold_left;
  int items_sent;
  int chars_checked;
  int mismatches;
  int tags_converted;
  int entities_decoded;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[html_tag_strip_filter] ERROR");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(0, 99) < 14);
      end
    end
  end

  function automatic void report_mismatch(input string what, input text_char_t exp_c,
                                          input text_char_t got_c);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("%0t: %s: expected byte %h last %b, got byte %h last %b", $realtime, what,
               exp_c.ch, exp_c.last, got_c.ch, got_c.last);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t got_c;
    text_char_t exp_c;
    if (rst_n && out_if.valid && out_if.ready) begin
      got_c.ch = out_if.out_byte;
      got_c.last = out_if.last_of_run;
      chars_checked++;
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected output", '0, got_c);
      end else begin
        exp_c = expected_text.pop_front();
        if (exp_c.ch !== got_c.ch || exp_c.last !== got_c.last) begin
          report_mismatch("wrong output", exp_c, got_c);
        end
      end
    end
  end

  function automatic void clear_filter_state();
    in_tag = 1'b0;
    tag_cnt = '0;
    live_tags = CAND_ALL;
    amp_step = ENT_IDLE;
    for (int i = 0; i < 4; i++) begin
      amp_buf[i] = CH_NUL;
    end
  endfunction

  function automatic void push_amp_raw(input int count);
    bit stop;
    stop = 1'b0;
    run_q.push_back(CH_AMP);
    for (int i = 0; i < count && i < 4; i++) begin
      if (amp_buf[i] == CH_NUL || amp_buf[i] == CH_CUT) begin
        stop = 1'b1;
      end
      if (!stop) begin
        run_q.push_back(amp_buf[i]);
      end
    end
  endfunction

  function automatic void strip_byte(input logic [7:0] c, input logic eoi);
    logic [7:0] lc;
    text_char_t tc;
    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
    run_q.delete();
    if (eoi) begin
      if (amp_step != ENT_IDLE) begin
        push_amp_raw(int'(amp_step) - 1);
      end
      clear_filter_state();
    end else if (amp_step != ENT_IDLE) begin
      amp_buf[int'(amp_step) - 1] = c;
      amp_step = amp_step + 3'd1;
      if (amp_step == ENT_FOURTH) begin
        if (amp_buf[0] == CH_LOW_G && amp_buf[1] == CH_LOW_T && amp_buf[2] == CH_SEMI) begin
          run_q.push_back(CH_GT);
          amp_step = ENT_IDLE;
          entities_decoded++;
        end else if (amp_buf[0] == CH_LOW_L && amp_buf[1] == CH_LOW_T &&
                     amp_buf[2] == CH_SEMI) begin
          run_q.push_back(CH_LT);
          amp_step = ENT_IDLE;
          entities_decoded++;
        end else if (!(amp_buf[0] == CH_LOW_A && amp_buf[1] == CH_LOW_M &&
                       amp_buf[2] == CH_LOW_P)) begin
          push_amp_raw(3);
          amp_step = ENT_IDLE;
        end
      end else if (amp_step > ENT_FOURTH) begin
        if (amp_buf[3] == CH_SEMI) begin
          run_q.push_back(CH_AMP);
          entities_decoded++;
        end else begin
          push_amp_raw(4);
        end
        amp_step = ENT_IDLE;
      end
    end else if (c == CH_LT) begin
      in_tag = 1'b1;
      tag_cnt = '0;
      live_tags = CAND_ALL;
    end else if (c == CH_GT) begin
      if (in_tag && conv_mode) begin
        if ((live_tags[CAND_BR] && tag_cnt == 3'd2) ||
            (live_tags[CAND_P] && tag_cnt == 3'd1)) begin
          run_q.push_back(CH_NL);
          tags_converted++;
        end else if (live_tags[CAND_HR] && tag_cnt == 3'd2) begin
          run_q.push_back(CH_NL);
          for (int i = 0; i < RULE_LEN; i++) begin
            run_q.push_back(CH_DASH);
          end
          run_q.push_back(CH_NL);
          tags_converted++;
        end
      end
      in_tag = 1'b0;
      tag_cnt = '0;
      live_tags = CAND_ALL;
    end else if (in_tag) begin
      if (tag_cnt == 3'd0) begin
        if (lc != CH_LOW_B) live_tags[CAND_BR] = 1'b0;
        if (lc != CH_LOW_P) live_tags[CAND_P] = 1'b0;
        if (lc != CH_LOW_H) live_tags[CAND_HR] = 1'b0;
      end else if (tag_cnt == 3'd1) begin
        live_tags[CAND_P] = 1'b0;
        if (lc != CH_LOW_R) begin
          live_tags[CAND_BR] = 1'b0;
          live_tags[CAND_HR] = 1'b0;
        end
      end else begin
        live_tags = '0;
      end
      if (tag_cnt != TAG_LEN_MAX) begin
        tag_cnt = tag_cnt + 3'd1;
      end
    end else if (c == CH_AMP) begin
      amp_step = ENT_START;
    end else begin
      run_q.push_back(c);
    end
    foreach (run_q[i]) begin
      tc.ch = run_q[i];
      tc.last = (i == run_q.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 14) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.end_of_input <= eoi;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    strip_byte(b, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_convert(input logic v);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    conv_mode = v;
  endtask

  function automatic string mixed_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++) begin
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1) == 1) begin
        r[i] = r[i] - 8'd32;
      end
    end
    return r;
  endfunction

  task automatic send_random_token();
    int    kind;
    int    n;
    string tag_chars;
    string ent_chars;
    tag_chars = "bhprxBHPR";
    ent_chars = "amp;<>&";
    kind = $urandom_range(0, 19);
    if (kind < 8) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 12) begin
      case ($urandom_range(0, 5))
        0: send_text({"<", mixed_case("br"), ">"});
        1: send_text({"<", mixed_case("p"), ">"});
        2: send_text({"<", mixed_case("hr"), ">"});
        default: begin
          send_text("<");
          n = $urandom_range(0, 9);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
              send_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
              send_item(tag_chars[$urandom_range(0, 8)], 1'b0);
            end
          end
          send_text(">");
        end
      endcase
    end else if (kind < 17) begin
      send_text("&");
      case ($urandom_range(0, 6))
        0: send_text("gt;");
        1: send_text("lt;");
        2: send_text("amp;");
        3: send_text("amp");
        4: send_text(mixed_case("gt;"));
        default: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
              0: send_item(CH_NUL, 1'b0);
              1: send_item(CH_CUT, 1'b0);
              2: send_item(ent_chars[$urandom_range(0, 6)], 1'b0);
              default: send_item(8'($urandom_range(0, 255)), 1'b0);
            endcase
          end
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        send_end();
      end
    end else if (kind < 18) begin
      send_end();
    end else begin
      send_text(">");
    end
  endtask

  task automatic reset_block();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.end_of_input = 1'b0;
    conv_mode = 1'b0;
    clear_filter_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_passthrough();
    send_item(CH_NUL, 1'b0);
    send_item(CH_CUT, 1'b0);
    send_text("z>");
    send_text("<br>");
    set_convert(1'b1);
  endtask

  task automatic test_tag_conversion();
    send_text("<bR><P><Hr><>");
    send_text("<b<br><hrx>");
    send_text("<hrhrhrhrh>");
  endtask

  task automatic test_entities();
    send_text("&gt;&lt;&amp;&am");
    send_item(CH_CUT, 1'b0);
    send_text("&a<>&");
    send_text("&amp");
    send_end();
    send_text("&g");
    send_item(CH_NUL, 1'b0);
    send_text("x");
    send_end();
    send_text("<b");
    send_end();
    send_text("r>");
  endtask

  task automatic test_random_mix(input int n, input logic conv, input bit with_idle);
    int start;
    set_convert(conv);
    idle_on = with_idle;
    start = items_sent;
    while (items_sent - start < n) begin
      send_random_token();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_convert(1'b1);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_text("<hr>ab&lt;");
    end
  endtask

  initial begin
    idle_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    reset_block();
    test_passthrough();
    test_tag_conversion();
    test_entities();
    test_random_mix(110, 1'b1, 1'b1);
    test_random_mix(70, 1'b0, 1'b1);
    test_backpressure();
    test_random_mix(90, 1'b1, 1'b0);
    test_random_mix(90, 1'b1, 1'b1);
    set_convert(1'b0);
    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d input items and %0d output bytes,", items_sent, chars_checked);
    $display("with %0d converted tags, %0d decoded entities and a %0d cycle output hold-off.",
             tags_converted, entities_decoded, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[html_tag_strip_filter] OK");
    end else begin
      $display("[html_tag_strip_filter] ERROR");
    end
    $finish;
  end

endmodule

// File: html_tag_strip_filter.f
+incdir+rtl
rtl/hts_pkg.sv
rtl/hts_in_if.sv
rtl/hts_out_if.sv
rtl/hts_parse.sv
rtl/hts_emit.sv
rtl/html_tag_strip_filter.sv
tb/tb.sv
